// ----- sv/hcwa_pkg.sv -----
package hcwa_pkg;

  // Compact difficulty word layout.
  localparam logic [31:0] SIGN_FLAG = 32'h0080_0000;
  localparam logic [31:0] MANT_MASK = 32'h007f_ffff;
  localparam int unsigned MANT_W    = 23;
  localparam logic [7:0]  EXP_BIAS  = 8'd3;

  // Width of one result slice.
  localparam int unsigned WORD_W = 64;

  // Classification that travels with each decoded target.
  typedef struct packed {
    logic use_work;
    logic last;
  } hcwa_flags_t;

endpackage

// ----- sv/hcwa_front.sv -----
module hcwa_front #(
  parameter int unsigned WORK_BITS = 256
) (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            compact_bits,
  input  logic                   last_header,
  input  logic                   q_full,
  output logic                   push,
  output logic [WORK_BITS-1:0]   push_target,
  output hcwa_pkg::hcwa_flags_t  push_flags
);
  import hcwa_pkg::*;

  logic [7:0]        expo;
  logic [MANT_W-1:0] mant;
  logic [4:0]        rsh;
  logic [10:0]       lsh;
  logic              negative;
  logic              overflow;
  logic [WORK_BITS-1:0] wide_mant;

  // A beat is taken whenever the queue has room.
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Decode the compact word: small exponents shift the mantissa right,
  // larger ones shift it left by whole bytes.
  always_comb begin
    expo = compact_bits[31:24];
    mant = MANT_W'(compact_bits & MANT_MASK);
    rsh  = '0;
    lsh  = '0;
    if (expo <= EXP_BIAS) begin
      rsh  = {2'(EXP_BIAS - expo), 3'b000};
      mant = mant >> rsh;
    end else begin
      lsh = {8'(expo - EXP_BIAS), 3'b000};
    end
    wide_mant = WORK_BITS'(mant);
  end

  // Classify: negative, overflowing and zero targets add no work.
  always_comb begin
    negative = (mant != '0) && ((compact_bits & SIGN_FLAG) != '0);
    overflow = (mant != '0) &&
               ((expo > 8'd34) ||
                ((mant > MANT_W'(32'h0000_00ff)) && (expo > 8'd33)) ||
                ((mant > MANT_W'(32'h0000_ffff)) && (expo > 8'd32)));
    push_flags.use_work = !negative && !overflow && (mant != '0);
    push_flags.last     = last_header;
    if (expo <= EXP_BIAS) begin
      push_target = wide_mant;
    end else begin
      push_target = wide_mant << lsh;
    end
  end

endmodule

// ----- sv/hcwa_queue.sv -----
module hcwa_queue #(
  parameter int unsigned WORK_BITS = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WORK_BITS-1:0]   push_target,
  input  hcwa_pkg::hcwa_flags_t  push_flags,
  output logic                   full,
  input  logic                   pop,
  output logic                   empty,
  output logic [WORK_BITS-1:0]   pop_target,
  output hcwa_pkg::hcwa_flags_t  pop_flags
);
  import hcwa_pkg::*;

  localparam int unsigned DEPTH = 2;

  logic [WORK_BITS-1:0] targets [DEPTH];
  hcwa_flags_t          flags   [DEPTH];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;

  assign full       = (count == 2'(DEPTH));
  assign empty      = (count == 2'd0);
  assign pop_target = targets[rd_ptr];
  assign pop_flags  = flags[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      targets[wr_ptr] <= push_target;
      flags[wr_ptr]   <= push_flags;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- sv/hcwa_back.sv -----
module hcwa_back #(
  parameter int unsigned WORK_BITS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  logic [WORK_BITS-1:0]          q_target,
  input  hcwa_pkg::hcwa_flags_t         q_flags,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hcwa_pkg::WORD_W-1:0]   work_word,
  output logic [$clog2(WORK_BITS/hcwa_pkg::WORD_W)-1:0] word_index,
  output logic                          last_word
);
  import hcwa_pkg::*;

  localparam int unsigned WORDS = WORK_BITS / WORD_W;
  localparam int unsigned IDX_W = $clog2(WORDS);
  localparam int unsigned CNT_W = $clog2(WORK_BITS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]           state;
  logic                 last;
  logic [CNT_W-1:0]     cnt;
  logic [WORK_BITS-1:0] divisor;
  logic [WORK_BITS-1:0] numer;
  logic [WORK_BITS-1:0] rem;
  logic [WORK_BITS-1:0] quot;
  logic [WORK_BITS-1:0] total;
  logic [IDX_W-1:0]     idx;
  logic [WORK_BITS-1:0] rem_sh;
  logic [WORK_BITS:0]   diff;

  assign pop        = (state == S_IDLE) && !q_empty;
  assign out_valid  = (state == S_EMIT);
  assign work_word  = total[idx*WORD_W +: WORD_W];
  assign word_index = idx;
  assign last_word  = (idx == IDX_W'(WORDS - 1));

  // One restoring division step: shift in the next numerator bit and
  // try to subtract the divisor.
  always_comb begin
    rem_sh = {rem[WORK_BITS-2:0], numer[WORK_BITS-1]};
    diff   = {1'b0, rem_sh} - {1'b0, divisor};
  end

  // Sequencer: load, divide bit by bit, accumulate, then stream the total.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      idx   <= '0;
      last  <= 1'b0;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            last <= q_flags.last;
            idx  <= '0;
            if (q_flags.use_work) begin
              divisor <= q_target + WORK_BITS'(1);
              numer   <= ~q_target;
              rem     <= '0;
              quot    <= '0;
              cnt     <= CNT_W'(WORK_BITS - 1);
              state   <= S_DIV;
            end else if (q_flags.last) begin
              state <= S_EMIT;
            end
          end
        end
        S_DIV: begin
          numer <= numer << 1;
          if (!diff[WORK_BITS]) begin
            rem  <= diff[WORK_BITS-1:0];
            quot <= {quot[WORK_BITS-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            quot <= {quot[WORK_BITS-2:0], 1'b0};
          end
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          // Work of one header is quotient plus one.
          total <= total + quot + WORK_BITS'(1);
          state <= last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_ready) begin
            if (idx == IDX_W'(WORDS - 1)) begin
              total <= '0;
              idx   <= '0;
              state <= S_IDLE;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The divisor is never zero while dividing.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (divisor != '0))
    else $error("divider running with a zero divisor");

  // The total is cleared after its final slice is taken.
  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> (total == '0))
    else $error("total not cleared after the final slice");

  // Slices of the total do not change while one is being offered.
  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(idx) && $stable(total)))
    else $error("emitted slice changed while stalled");

endmodule

// ----- sv/header_chain_work_accumulator.sv -----
// Header chain work accumulator. Each input beat carries one compact difficulty
// word; it is decoded to a 256-bit target, and unless that target is negative,
// overflowing or zero, the header's work (~target / (target + 1)) + 1 is added
// to a 256-bit running total that wraps. On a beat marked last_header the total
// is sent out as four 64-bit beats, low word first, and then cleared. The front
// decodes a beat in the cycle it arrives and parks it in a two-entry queue, so
// input is taken as long as the queue has room. The back works on one header at a time
// and takes the next only when idle; for a header that adds work, the restoring divider
// produces one quotient bit per cycle, a skipped header needs no division, and a last
// header is followed by four output beats, which the receiver can stall.
module header_chain_work_accumulator #(
  parameter int unsigned WORK_BITS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [31:0]                          compact_bits,
  input  logic                                 last_header,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [hcwa_pkg::WORD_W-1:0]          work_word,
  output logic [$clog2(WORK_BITS/hcwa_pkg::WORD_W)-1:0] word_index,
  output logic                                 last_word
);
  import hcwa_pkg::*;

  logic                 push;
  logic [WORK_BITS-1:0] push_target;
  hcwa_flags_t          push_flags;
  logic                 q_full;
  logic                 q_empty;
  logic                 pop;
  logic [WORK_BITS-1:0] pop_target;
  hcwa_flags_t          pop_flags;

  // Decode and classify incoming beats.
  hcwa_front #(.WORK_BITS(WORK_BITS)) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .compact_bits (compact_bits),
    .last_header  (last_header),
    .q_full       (q_full),
    .push         (push),
    .push_target  (push_target),
    .push_flags   (push_flags)
  );

  // Decoded headers waiting for the divider.
  hcwa_queue #(.WORK_BITS(WORK_BITS)) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_target (push_target),
    .push_flags  (push_flags),
    .full        (q_full),
    .pop         (pop),
    .empty       (q_empty),
    .pop_target  (pop_target),
    .pop_flags   (pop_flags)
  );

  // Divide, accumulate and stream the total.
  hcwa_back #(.WORK_BITS(WORK_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_target   (pop_target),
    .q_flags    (pop_flags),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .work_word  (work_word),
    .word_index (word_index),
    .last_word  (last_word)
  );

endmodule

// ----- tb/tb.sv -----
module tb;

  import hcwa_pkg::*;

  localparam int unsigned WORK_BITS   = 256;
  localparam int unsigned SLICES      = WORK_BITS / WORD_W;
  // One working header plus a full set of output beats, with margin.
  localparam int unsigned SETTLE_CYCLES = 300;

  // One expected output beat of the accumulated work.
  typedef struct {
    logic [WORD_W-1:0] word;
    logic [1:0]        index;
    logic              fin;
  } work_slice_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [31:0]       compact_bits = '0;
  logic              last_header = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [WORD_W-1:0] work_word;
  logic [1:0]        word_index;
  logic              last_word;

  // Running total as the block should hold it, and the beats still owed.
  logic [WORK_BITS-1:0] chain_work = '0;
  work_slice_t          slices_due[$];
  int unsigned          mismatches = 0;

  // Idle controls for the two sides and the receiver hold-off request.
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int hold_req = 0;
  int hold_left = 0;

  header_chain_work_accumulator #(.WORK_BITS(WORK_BITS)) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .compact_bits (compact_bits),
    .last_header  (last_header),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .work_word    (work_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Work contributed by one compact word; skipped headers contribute zero.
  function automatic logic [WORK_BITS-1:0] header_work(input logic [31:0] cbits);
    logic [7:0]           expo;
    logic [MANT_W-1:0]    mant;
    logic [WORK_BITS-1:0] tgt;
    logic                 neg;
    logic                 ovf;
    expo = cbits[31:24];
    mant = cbits[MANT_W-1:0];
    if (expo <= EXP_BIAS) begin
      mant = mant >> (8 * (EXP_BIAS - expo));
    end
    neg = (mant != 0) && ((cbits & SIGN_FLAG) != 0);
    ovf = (mant != 0) && (expo > 34 || (mant > 'hff && expo > 33) ||
                          (mant > 'hffff && expo > 32));
    if (neg || ovf || mant == 0) begin
      return '0;
    end
    if (expo <= EXP_BIAS) begin
      tgt = WORK_BITS'(mant);
    end else begin
      tgt = WORK_BITS'(mant) << (8 * (expo - EXP_BIAS));
    end
    return (~tgt / (tgt + 1)) + 1;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Offer one header, wait for its beat, then fold it into the prediction.
  task automatic send_header(input logic [31:0] cbits, input logic fin);
    work_slice_t s;
    while (tx_gaps && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    compact_bits <= cbits;
    last_header  <= fin;
    do @(posedge clk); while (!in_ready);
    chain_work = chain_work + header_work(cbits);
    if (fin) begin
      for (int i = 0; i < SLICES; i++) begin
        s.word  = chain_work[WORD_W*i +: WORD_W];
        s.index = 2'(i);
        s.fin   = (i == SLICES - 1);
        slices_due.push_back(s);
      end
      chain_work = '0;
    end
  endtask

  // Stop offering and hold until every owed beat has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (slices_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rx_gaps ? ($urandom_range(0, 99) >= 12) : 1'b1;
    end
  end

  // Compare each output beat with the oldest owed slice.
  always @(posedge clk) begin
    work_slice_t want;
    if (!rst && out_valid && out_ready) begin
      if (slices_due.size() == 0) begin
        flag_mismatch($sformatf("beat with nothing owed: idx %0d word %h",
                                word_index, work_word));
      end else begin
        want = slices_due.pop_front();
        if (work_word !== want.word)
          flag_mismatch($sformatf("work_word %h, want %h", work_word, want.word));
        if (word_index !== want.index)
          flag_mismatch($sformatf("word_index %0d, want %0d", word_index, want.index));
        if (last_word !== want.fin)
          flag_mismatch($sformatf("last_word %b, want %b", last_word, want.fin));
      end
    end
  end

  // Field extremes and every decode rule: shifts, sign, overflow, zero, wrap.
  task automatic test_decode_corners();
    send_header(32'h0000_0000, 1'b1);  // batch of one zero target
    send_header(32'h0100_3456, 1'b0);  // small exponent shifts the mantissa away
    send_header(32'h0112_3456, 1'b0);  // small exponent keeps the top byte
    send_header(32'h0200_8000, 1'b1);
    send_header(32'h0300_0001, 1'b0);  // target of one gives half the range
    send_header(32'h0300_0001, 1'b0);  // a second one wraps the total
    send_header(32'h0300_0001, 1'b1);
    send_header(32'h0492_3456, 1'b0);  // negative target
    send_header(32'h0180_3456, 1'b0);  // sign set but shifted mantissa is zero
    send_header(32'h0480_0000, 1'b0);  // sign set with zero mantissa
    send_header(32'h00ff_ffff, 1'b0);  // exponent zero clears everything
    send_header(32'h1d00_ffff, 1'b1);
    send_header(32'h207f_ffff, 1'b0);  // largest mantissa at the last safe size
    send_header(32'h2101_0000, 1'b0);  // overflow above sixteen mantissa bits
    send_header(32'h2100_ffff, 1'b0);
    send_header(32'h2200_0100, 1'b0);  // overflow above eight mantissa bits
    send_header(32'h2200_00ff, 1'b1);
    send_header(32'h2300_0001, 1'b0);  // overflow on exponent alone
    send_header(32'hff7f_ffff, 1'b0);
    send_header(32'hff00_0000, 1'b0);  // huge exponent but zero mantissa
    send_header(32'h037f_ffff, 1'b1);
    send_header(32'hffff_ffff, 1'b1);  // batch of only a skipped header
    wait_drain();
  endtask

  // Hold the output off long enough for the block to back up into its input.
  task automatic test_backpressure_fill();
    hold_req = 600;
    for (int i = 0; i < 8; i++) begin
      send_header({8'($urandom_range(4, 32)), 1'b0, 23'($urandom)}, i % 3 == 2);
    end
    send_header(32'h1b04_04cb, 1'b1);
    wait_drain();
  endtask

  // Mostly usable targets with random content, plus raw random words.
  task automatic test_random_headers(input int unsigned count);
    logic [31:0] cbits;
    logic        fin;
    for (int unsigned i = 0; i < count; i++) begin
      // The first stretch runs with neither side idling.
      tx_gaps = (i >= 30);
      rx_gaps = (i >= 30);
      if ($urandom_range(0, 99) < 75) begin
        cbits = {8'($urandom_range(0, 34)), 1'b0, 23'($urandom)};
      end else begin
        cbits = $urandom;
      end
      fin = ($urandom_range(0, 4) == 0) || (i == count - 1);
      send_header(cbits, fin);
    end
    wait_drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_decode_corners();
    test_backpressure_fill();
    test_random_headers(70);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
